// ===== rtl/sfdc_pkg.sv =====
package sfdc_pkg;

    // Default framing markers
    localparam logic [7:0] START_MARKER_RST = 8'hBB;
    localparam logic [7:0] END_MARKER_RST   = 8'h7E;

    // Packed tail of the payload
    localparam int WORD_BYTES = 8;
    localparam int WORD_BITS  = 8 * WORD_BYTES;
    localparam int OUT_WORD_W = 64;

    // Result beat width, padded to whole bytes
    localparam int RES_BITS   = 2 + 5 * 8 + OUT_WORD_W + 1;
    localparam int RES_TDATA_W = ((RES_BITS + 7) / 8) * 8;

    // Configuration register indices
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 1'b1;

    // Known command set for type zero
    localparam logic [7:0] TYPE_SYSTEM  = 8'h00;
    localparam logic [7:0] CMD_A        = 8'h02;
    localparam logic [7:0] CMD_RANGE_LO = 8'h08;
    localparam logic [7:0] CMD_RANGE_HI = 8'h0C;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_TYPE,
        PH_CMD,
        PH_LEN,
        PH_PAYLOAD,
        PH_CHECK,
        PH_END
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SUM_ERR = 2'd1,
        ST_END_ERR = 2'd2
    } t_status;

    typedef struct packed {
        logic                  known;
        logic [OUT_WORD_W-1:0] word;
        logic [7:0]            second;
        logic [7:0]            first;
        logic [7:0]            length;
        logic [7:0]            command;
        logic [7:0]            ftype;
        t_status               status;
    } t_result;

    function automatic logic is_known(input logic [7:0] ftype, input logic [7:0] cmd);
        logic hit;
        begin
            hit = 1'b0;
            if (ftype == TYPE_SYSTEM) begin
                hit = (cmd inside {CMD_A, [CMD_RANGE_LO:CMD_RANGE_HI]});
            end
            return hit;
        end
    endfunction

endpackage

// ===== rtl/sfdc_parser.sv =====
module sfdc_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_beat,
    input  logic [7:0]         i_byte,
    input  logic [7:0]         i_start_marker,
    input  logic [7:0]         i_end_marker,
    output logic               o_emit,
    output sfdc_pkg::t_result  o_result
);
    import sfdc_pkg::*;

    t_phase                r_phase, n_phase;
    logic [7:0]            r_type, n_type;
    logic [7:0]            r_cmd, n_cmd;
    logic [7:0]            r_len, n_len;
    logic [7:0]            r_seen, n_seen;
    logic [7:0]            r_sum, n_sum;
    logic [WORD_BITS-1:0]  r_pack, n_pack;
    logic [15:0]           r_first2, n_first2;
    logic [WORD_BITS+7:0]  shifted;
    logic [7:0]            sum_add;
    t_status               status;

    assign shifted = {r_pack, i_byte};
    assign sum_add = r_sum + i_byte;

    // Phase register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
        end else if (i_beat) begin
            r_phase <= n_phase;
        end
    end

    // Frame fields, only meaningful once a frame has been opened
    always_ff @(posedge i_clk) begin
        if (i_beat) begin
            r_type   <= n_type;
            r_cmd    <= n_cmd;
            r_len    <= n_len;
            r_seen   <= n_seen;
            r_sum    <= n_sum;
            r_pack   <= n_pack;
            r_first2 <= n_first2;
        end
    end

    // Per-byte parse step
    always_comb begin
        n_phase  = r_phase;
        n_type   = r_type;
        n_cmd    = r_cmd;
        n_len    = r_len;
        n_seen   = r_seen;
        n_sum    = r_sum;
        n_pack   = r_pack;
        n_first2 = r_first2;
        o_emit   = 1'b0;
        status   = ST_OK;
        case (r_phase)
            PH_HUNT: begin
                if (i_byte == i_start_marker) begin
                    n_phase = PH_TYPE;
                end
            end
            PH_TYPE: begin
                n_type  = i_byte;
                n_sum   = i_byte;
                n_phase = PH_CMD;
            end
            PH_CMD: begin
                n_cmd   = i_byte;
                n_sum   = sum_add;
                n_phase = PH_LEN;
            end
            PH_LEN: begin
                n_len    = i_byte;
                n_sum    = sum_add;
                n_seen   = 8'd0;
                n_pack   = '0;
                n_first2 = 16'd0;
                n_phase  = (i_byte != 8'd0) ? PH_PAYLOAD : PH_CHECK;
            end
            PH_PAYLOAD: begin
                n_sum = sum_add;
                if (r_seen == 8'd0) begin
                    n_first2 = {i_byte, 8'd0};
                end else if (r_seen == 8'd1) begin
                    n_first2 = {r_first2[15:8], i_byte};
                end
                n_pack = shifted[WORD_BITS-1:0];
                n_seen = r_seen + 8'd1;
                if (n_seen >= r_len) begin
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                if (i_byte != r_sum) begin
                    o_emit  = 1'b1;
                    status  = ST_SUM_ERR;
                    n_phase = PH_HUNT;
                end else begin
                    n_phase = PH_END;
                end
            end
            PH_END: begin
                o_emit  = 1'b1;
                status  = (i_byte == i_end_marker) ? ST_OK : ST_END_ERR;
                n_phase = PH_HUNT;
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    // Result fields come from the held frame state; the status comes from the current byte
    always_comb begin
        o_result.status  = status;
        o_result.ftype   = r_type;
        o_result.command = r_cmd;
        o_result.length  = r_len;
        o_result.first   = r_first2[15:8];
        o_result.second  = r_first2[7:0];
        o_result.word    = OUT_WORD_W'(r_pack);
        o_result.known   = is_known(r_type, r_cmd);
    end

endmodule

// ===== rtl/serial_frame_deframer_checksum_top.sv =====
// Channel   Dir  Width  Contents
// s_axis    in   8      rx_byte
// m_axis    out  112    frame result, one beat per frame
// cfg       in   8      start_marker (index 0), end_marker (index 1)
//
// One received byte is taken per cycle unless s_axis_tready is low; a result
// beat appears the cycle after the checksum byte (mismatch) or the end byte
// that completes a frame. The result register frees the input: s_axis_tready
// falls only while a result waits and m_axis_tready is low.
// Reset is synchronous and active low; it returns the parser to start-marker
// hunting and restores the default markers.
module serial_frame_deframer_checksum_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [7:0] rx_byte
    input  logic [7:0]                        s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [1:0] frame_status, [9:2] frame_type, [17:10] command_code,
    // [25:18] payload_length, [33:26] payload_first, [41:34] payload_second,
    // [105:42] payload_word, [106] known_command, [111:107] zero
    output logic [sfdc_pkg::RES_TDATA_W-1:0]  m_axis_tdata,
    input  logic                              i_cfg_we,
    input  logic [sfdc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [7:0]                        i_cfg_data
);
    import sfdc_pkg::*;

    logic [7:0] r_start_marker;
    logic [7:0] r_end_marker;
    logic       r_out_valid;
    t_result    r_out;
    logic       beat;
    logic       emit;
    t_result    result;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign beat          = s_axis_tvalid && s_axis_tready;

    // Marker registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= START_MARKER_RST;
            r_end_marker   <= END_MARKER_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START_MARKER: r_start_marker <= i_cfg_data;
                CFG_END_MARKER:   r_end_marker   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    sfdc_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_beat         (beat),
        .i_byte         (s_axis_tdata),
        .i_start_marker (r_start_marker),
        .i_end_marker   (r_end_marker),
        .o_emit         (emit),
        .o_result       (result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (beat && emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (beat && emit) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = RES_TDATA_W'(r_out);

endmodule

// ===== rtl/sfdc_checker.sv =====
module sfdc_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [sfdc_pkg::RES_TDATA_W-1:0]  m_axis_tdata
);
    import sfdc_pkg::*;

    // A stalled result beat holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat dropped or changed while stalled");

    // Input is refused only while a result waits unaccepted
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow the result register");

    // A new result needs an input beat in the previous cycle
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !$past(m_axis_tvalid && !m_axis_tready)
        |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("result beat without an input beat");

    // Reset empties the result register
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // Status is never the unused code
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] == ST_OK || m_axis_tdata[1:0] == ST_SUM_ERR
                           || m_axis_tdata[1:0] == ST_END_ERR))
        else $error("illegal frame status");

endmodule

bind serial_frame_deframer_checksum_top sfdc_checker u_sfdc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import sfdc_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 4;
    localparam int TARGET_BYTES  = 1650;

    // DUT connections
    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [7:0]              s_axis_tdata = 8'h00;     // [7:0] rx_byte
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [RES_TDATA_W-1:0]  m_axis_tdata;             // status, type, cmd, len, first,
                                                       // second, word, known, pad
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx = '0;
    logic [7:0]              i_cfg_data = 8'h00;

    // Deframer shadow state
    logic [7:0]  start_byte = START_MARKER_RST;
    logic [7:0]  end_byte   = END_MARKER_RST;
    t_phase      cur_phase  = PH_HUNT;
    logic [7:0]  frm_type   = 8'h00;
    logic [7:0]  frm_cmd    = 8'h00;
    logic [7:0]  frm_len    = 8'h00;
    logic [7:0]  pay_count  = 8'h00;
    logic [7:0]  sum_acc    = 8'h00;
    logic [63:0] tail_word  = 64'h0;
    logic [7:0]  pay_first  = 8'h00;
    logic [7:0]  pay_second = 8'h00;

    t_result     frames_due[$];
    t_result     seen_frame;
    t_result     due_frame;
    logic [7:0]  pay_buf[0:255];

    int  framed_bytes = 0;
    int  frames_checked = 0;
    int  mismatches = 0;
    int  cycle_count = 0;
    bit  no_idle = 1'b0;

    serial_frame_deframer_checksum_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Advance the shadow parser by one accepted byte
    function automatic void deframe_byte(input logic [7:0] b);
        logic    done;
        t_status st;
        t_result r;
        done = 1'b0;
        st   = ST_OK;
        if (!(cur_phase == PH_HUNT && b != start_byte))
            framed_bytes++;
        case (cur_phase)
            PH_TYPE: begin
                frm_type  = b;
                sum_acc   = b;
                cur_phase = PH_CMD;
            end
            PH_CMD: begin
                frm_cmd   = b;
                sum_acc   = sum_acc + b;
                cur_phase = PH_LEN;
            end
            PH_LEN: begin
                frm_len    = b;
                sum_acc    = sum_acc + b;
                pay_count  = 8'h00;
                tail_word  = 64'h0;
                pay_first  = 8'h00;
                pay_second = 8'h00;
                cur_phase  = (b != 8'h00) ? PH_PAYLOAD : PH_CHECK;
            end
            PH_PAYLOAD: begin
                sum_acc = sum_acc + b;
                if (pay_count == 8'd0)
                    pay_first = b;
                else if (pay_count == 8'd1)
                    pay_second = b;
                // keep only the last WORD_BYTES bytes
                tail_word = ((tail_word << 8) | 64'(b)) & ~({64{1'b1}} << WORD_BITS);
                pay_count = pay_count + 8'd1;
                if (pay_count >= frm_len)
                    cur_phase = PH_CHECK;
            end
            PH_CHECK: begin
                if (b != sum_acc) begin
                    done = 1'b1;
                    st   = ST_SUM_ERR;
                end else begin
                    cur_phase = PH_END;
                end
            end
            PH_END: begin
                done = 1'b1;
                st   = (b == end_byte) ? ST_OK : ST_END_ERR;
            end
            default: begin
                cur_phase = (b == start_byte) ? PH_TYPE : PH_HUNT;
            end
        endcase
        if (done) begin
            r.status  = st;
            r.ftype   = frm_type;
            r.command = frm_cmd;
            r.length  = frm_len;
            r.first   = pay_first;
            r.second  = pay_second;
            r.word    = tail_word;
            r.known   = (frm_type == TYPE_SYSTEM) &&
                        (frm_cmd == CMD_A ||
                         (frm_cmd >= CMD_RANGE_LO && frm_cmd <= CMD_RANGE_HI));
            frames_due.push_back(r);
            cur_phase = PH_HUNT;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch frame %0d %s: got %h want %h", frames_checked, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // Result beat checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_frame = t_result'(m_axis_tdata[RES_BITS-1:0]);
            if (m_axis_tdata[RES_TDATA_W-1:RES_BITS] !== '0)
                report_mismatch("pad bits", 64'(m_axis_tdata[RES_TDATA_W-1:RES_BITS]), 64'h0);
            if (frames_due.size() == 0) begin
                report_mismatch("unexpected beat", 64'(seen_frame.status), 64'h0);
            end else begin
                due_frame = frames_due.pop_front();
                check_field("frame_status", 64'(seen_frame.status), 64'(due_frame.status));
                check_field("frame_type", 64'(seen_frame.ftype), 64'(due_frame.ftype));
                check_field("command_code", 64'(seen_frame.command), 64'(due_frame.command));
                check_field("payload_length", 64'(seen_frame.length), 64'(due_frame.length));
                check_field("payload_first", 64'(seen_frame.first), 64'(due_frame.first));
                check_field("payload_second", 64'(seen_frame.second), 64'(due_frame.second));
                check_field("payload_word", seen_frame.word, due_frame.word);
                check_field("known_command", 64'(seen_frame.known), 64'(due_frame.known));
            end
            frames_checked++;
        end
    end

    // Sink side: random stalls, none while no_idle is set
    initial begin
        int run;
        int gap;
        forever begin
            m_axis_tready <= 1'b1;
            run = $urandom_range(1, 20);
            repeat (run) @(posedge i_clk);
            gap = pick_gap();
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    // Send one byte; returns at the edge where the beat is taken
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        deframe_byte(b);
    endtask

    // Hold off the sender until every pending result is out
    task automatic settle_idle();
        s_axis_tvalid <= 1'b0;
        while (frames_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        settle_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_START_MARKER)
            start_byte = val;
        else
            end_byte = val;
    endtask

    // Frame with payload from pay_buf; skews corrupt checksum or end byte
    task automatic send_frame(input logic [7:0] ftype, input logic [7:0] cmd,
                              input logic [7:0] len, input logic [7:0] sum_skew,
                              input logic [7:0] end_skew);
        logic [7:0] sum;
        sum = ftype + cmd + len;
        for (int k = 0; k < len; k++)
            sum = sum + pay_buf[k];
        send_byte(start_byte);
        send_byte(ftype);
        send_byte(cmd);
        send_byte(len);
        for (int k = 0; k < len; k++)
            send_byte(pay_buf[k]);
        send_byte(sum + sum_skew);
        send_byte(end_byte ^ end_skew);
    endtask

    // Default markers: hunting junk, a known command, bad sum, bad end
    task automatic test_basic_frames();
        send_byte(8'h00);
        send_byte(8'hFF);
        pay_buf[0] = 8'hAA;
        pay_buf[1] = 8'h55;
        send_frame(TYPE_SYSTEM, CMD_A, 8'd2, 8'h00, 8'h00);
        send_frame(8'hFF, 8'hFF, 8'd0, 8'h01, 8'h00);
        pay_buf[0] = 8'hFF;
        send_frame(TYPE_SYSTEM, CMD_RANGE_HI, 8'd1, 8'h00, 8'h81);
    endtask

    // Extreme marker values, markers carried as payload
    task automatic test_marker_registers();
        write_reg(CFG_START_MARKER, 8'h00);
        write_reg(CFG_END_MARKER, 8'hFF);
        pay_buf[0] = 8'h00;
        pay_buf[1] = 8'hFF;
        pay_buf[2] = START_MARKER_RST;
        send_frame(TYPE_SYSTEM, CMD_RANGE_LO, 8'd3, 8'h00, 8'h00);
    endtask

    // Mostly well-formed frames with random content, plus noise and truncation
    task automatic test_random_traffic();
        int r;
        int goal;
        int frames;
        logic [7:0] ftype;
        logic [7:0] cmd;
        logic [7:0] len;
        logic [7:0] sum_skew;
        logic [7:0] end_skew;
        goal = framed_bytes;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_START_MARKER, 8'hFF);
                    write_reg(CFG_END_MARKER, 8'h00);
                end
                3: begin
                    write_reg(CFG_START_MARKER, START_MARKER_RST);
                    write_reg(CFG_END_MARKER, END_MARKER_RST);
                end
                default: begin
                    write_reg(CFG_START_MARKER, 8'($urandom_range(0, 255)));
                    write_reg(CFG_END_MARKER, 8'($urandom_range(0, 255)));
                end
            endcase
            no_idle = (ph == 2);
            goal   += TARGET_BYTES / 4;
            frames  = 0;
            while (framed_bytes < goal) begin
                r = $urandom_range(0, 99);
                if (r < 20) begin
                    repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
                end else if (r < 25) begin
                    // frame cut short; the next frame runs on as its content
                    send_byte(start_byte);
                    repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
                end
                ftype = ($urandom_range(0, 9) < 4) ? TYPE_SYSTEM : 8'($urandom_range(0, 255));
                r = $urandom_range(0, 9);
                if (r < 5)
                    cmd = 8'($urandom_range(0, 15));
                else if (r < 7)
                    cmd = ($urandom_range(0, 1) != 0) ? CMD_A : 8'($urandom_range(8, 12));
                else
                    cmd = 8'($urandom_range(0, 255));
                r = $urandom_range(0, 99);
                if (r < 10)
                    len = 8'd0;
                else if (r < 75)
                    len = 8'($urandom_range(1, 8));
                else if (r < 97)
                    len = 8'($urandom_range(9, 24));
                else
                    len = 8'($urandom_range(200, 255));
                for (int k = 0; k < len; k++) begin
                    r = $urandom_range(0, 19);
                    pay_buf[k] = (r == 0) ? start_byte :
                                 (r == 1) ? end_byte : 8'($urandom_range(0, 255));
                end
                sum_skew = ($urandom_range(0, 99) < 12) ? 8'($urandom_range(1, 255)) : 8'h00;
                end_skew = ($urandom_range(0, 99) < 12) ? 8'($urandom_range(1, 255)) : 8'h00;
                send_frame(ftype, cmd, len, sum_skew, end_skew);
                frames++;
                if (frames % 25 == 0)
                    settle_idle();
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_basic_frames();
        test_marker_registers();
        test_random_traffic();
        settle_idle();
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
